FILE: src/aat_pkg.sv
// Package for the ASID allocator with hashed TLB: payload structs, op codes,
// slot status codes, controller states and default sizes. No dependencies.
`default_nettype none
package aat_pkg;
  localparam int TableEntriesDef = 256;
  localparam int IdSlotsDef      = 256;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_LIVE  = 2'd1,
    ST_STALE = 2'd2,
    ST_RSVD  = 2'd3
  } slot_st_e;

  // controller states
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_EXEC, S_SCAN, S_ALLOC_WR,
    S_PSLOT, S_PTAB, S_PTAB_CHK, S_RSP
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  space_id;
    logic [19:0] virt_page;
    logic [31:0] mid_word;
    logic [31:0] attr_word;
    logic [15:0] owner_id;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  entry_index;
    logic [31:0] mid_out;
    logic [31:0] attr_out;
    logic [7:0]  given_id;
    logic        evicted_valid;
    logic [15:0] evicted_owner;
  } rsp_t;
endpackage
`default_nettype wire

FILE: src/aat_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module aat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: src/asid_allocator_with_hashed_tlb.sv
// ASID allocator with a direct-mapped, tagged translation table.
// Depends on aat_pkg and aat_ram.
//
// Channels: req (valid/ready, aat_pkg::req_t) in, rsp (valid/ready,
// aat_pkg::rsp_t) out; every request word gives exactly one response word.
// The table (tag, physical word, attribute word) and the slot table
// (status, owner) sit in synchronous RAMs with a registered read.
// Sequence per word: insert, lookup and release read the RAMs, execute and
// respond. Allocate scans the slots round-robin from the last given id for
// a free one; when none is free a purge runs: one sweep over the slot RAM
// frees the victim and stale ids, then one sweep over the table clears each
// entry whose tag's id status, read from the slot RAM, is free, or whose id
// is out of range.
// One word is in work at a time; the response register parts the sides,
// and a stalled receiver only holds the block once the next result is done.
// Reset: a clearing pass over every address of both RAMs writes zeros into
// them; no word is accepted until it ends.
`default_nettype none
module asid_allocator_with_hashed_tlb #(
  parameter int TableEntries = aat_pkg::TableEntriesDef,
  parameter int IdSlots      = aat_pkg::IdSlotsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire aat_pkg::req_t  req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_ready_i,
  output aat_pkg::rsp_t       rsp_o
);
  localparam int TW = $clog2(TableEntries);
  localparam int SW = $clog2(IdSlots);
  localparam int CW = ((TW > SW) ? TW : SW) + 1;
  localparam int ClrLen = (TableEntries > IdSlots) ? TableEntries : IdSlots;

  aat_pkg::state_e state_q, state_d;
  aat_pkg::req_t req_q;
  aat_pkg::rsp_t rsp_q, rsp_d, res_q, res_d;
  logic rsp_valid_q, rsp_valid_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] last_q, last_d, cur_q, cur_d;
  logic [TW-1:0] tidx_q, tidx_d;

  // RAM ports
  logic          t_we, s_we;
  logic [TW-1:0] t_wa, t_ra;
  logic [95:0]   t_wd, t_rd;
  logic [SW-1:0] s_wa, s_ra;
  logic [17:0]   s_wd, s_rd;
  logic t_we_f; logic [TW-1:0] t_wa_f; logic [95:0] t_wd_f;

  aat_ram #(.Width(96), .Depth(TableEntries)) u_tab (
    .clk_i, .we_i(t_we_f), .waddr_i(t_wa_f), .wdata_i(t_wd_f),
    .raddr_i(t_ra), .rdata_o(t_rd));
  aat_ram #(.Width(18), .Depth(IdSlots)) u_slot (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd),
    .raddr_i(s_ra), .rdata_o(s_rd));

  logic [31:0]   tag_w;
  logic [TW-1:0] idx_w;
  logic [31:0]   tab_tag;
  logic [1:0]    slot_st;
  logic [7:0]    tag_id;
  logic          tag_id_oor;
  logic [SW-1:0] nxt_id;

  assign tag_w = {req_q.virt_page, 12'd0} | {22'd0, req_q.space_id, 2'd0};
  assign idx_w = TW'(({12'd0, req_q.virt_page} ^ {22'd0, req_q.space_id, 2'd0}));
  assign tab_tag = t_rd[95:64];
  assign slot_st = s_rd[17:16];
  assign tag_id  = tab_tag[9:2];
  assign tag_id_oor = ({24'd0, tag_id} >= 32'(IdSlots));
  // round-robin successor over 1..IdSlots-1
  assign nxt_id = ({1'b0, cur_q} == (CW)'(IdSlots - 1)) ? SW'(1) : cur_q + SW'(1);

  assign req_ready_o = (state_q == aat_pkg::S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aat_pkg::S_CLR:  if (cnt_q == CW'(ClrLen - 1)) state_d = aat_pkg::S_IDLE;
      aat_pkg::S_IDLE: if (req_valid_i) state_d = aat_pkg::S_RD;
      aat_pkg::S_RD: begin
        state_d = (req_q.op == aat_pkg::OP_ALLOC) ? aat_pkg::S_SCAN : aat_pkg::S_EXEC;
      end
      aat_pkg::S_EXEC: state_d = aat_pkg::S_RSP;
      aat_pkg::S_SCAN: begin
        if (slot_st == aat_pkg::ST_FREE) state_d = aat_pkg::S_ALLOC_WR;
        else if (cnt_q == CW'(IdSlots - 2)) state_d = aat_pkg::S_PSLOT;
      end
      aat_pkg::S_ALLOC_WR: state_d = aat_pkg::S_RSP;
      aat_pkg::S_PSLOT: if (cnt_q == CW'(IdSlots)) state_d = aat_pkg::S_PTAB;
      aat_pkg::S_PTAB:  state_d = aat_pkg::S_PTAB_CHK;
      aat_pkg::S_PTAB_CHK: begin
        if (cnt_q == CW'(TableEntries + 1)) state_d = aat_pkg::S_ALLOC_WR;
      end
      aat_pkg::S_RSP: if (!rsp_valid_q || rsp_ready_i) state_d = aat_pkg::S_IDLE;
      default: state_d = aat_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cnt_d = cnt_q; last_d = last_q; cur_d = cur_q; tidx_d = tidx_q;
    res_d = res_q; rsp_d = rsp_q; rsp_valid_d = rsp_valid_q;
    t_we = 1'b0; t_wa = idx_w; t_wd = '0; t_ra = idx_w;
    s_we = 1'b0; s_wa = req_q.space_id[SW-1:0]; s_wd = '0;
    s_ra = req_q.space_id[SW-1:0];
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    unique case (state_q)
      aat_pkg::S_CLR: begin
        t_we = (cnt_q < CW'(TableEntries)); t_wa = cnt_q[TW-1:0];
        s_we = (cnt_q < CW'(IdSlots));      s_wa = cnt_q[SW-1:0];
        cnt_d = cnt_q + CW'(1);
      end
      aat_pkg::S_IDLE: begin
        res_d = '0; cnt_d = '0;
        cur_d = ({1'b0, last_q} >= CW'(IdSlots - 1)) ? SW'(1) : last_q + SW'(1);
      end
      // allocate reads its first candidate, the others the addressed slot
      aat_pkg::S_RD: if (req_q.op == aat_pkg::OP_ALLOC) s_ra = cur_q;
      aat_pkg::S_EXEC: begin
        res_d.entry_index = 8'(idx_w);
        case (req_q.op)
          aat_pkg::OP_INSERT: begin
            t_we = 1'b1; t_wd = {tag_w, req_q.mid_word, req_q.attr_word};
          end
          aat_pkg::OP_LOOKUP: if (tab_tag == tag_w) begin
            res_d.hit = 1'b1; res_d.mid_out = t_rd[63:32];
            res_d.attr_out = t_rd[31:0];
          end
          aat_pkg::OP_RELEASE: begin
            res_d.entry_index = '0;
            if ({24'd0, req_q.space_id} < 32'(IdSlots) && slot_st == aat_pkg::ST_LIVE) begin
              s_we = 1'b1; s_wd = {aat_pkg::ST_STALE, s_rd[15:0]};
            end
          end
          default: ;
        endcase
      end
      aat_pkg::S_SCAN: begin
        // s_rd holds the status of cur_q
        if (slot_st != aat_pkg::ST_FREE) begin
          if (cnt_q == CW'(IdSlots - 2)) begin
            cur_d = nxt_id; cnt_d = '0;
          end else begin
            cur_d = nxt_id; cnt_d = cnt_q + CW'(1);
          end
        end
        s_ra = (slot_st != aat_pkg::ST_FREE) ? nxt_id : cur_q;
      end
      aat_pkg::S_PSLOT: begin
        // cnt_q walks slot addresses; data of cnt_q-1 arrives now.
        // The victim is cur_q; free it, free stale ones.
        s_ra = cnt_q[SW-1:0];
        if (cnt_q != '0) begin
          s_wa = SW'(cnt_q - CW'(1));
          if (s_wa == cur_q) begin
            s_we = 1'b1; s_wd = {aat_pkg::ST_FREE, s_rd[15:0]};
            if (slot_st == aat_pkg::ST_LIVE) begin
              res_d.evicted_valid = 1'b1; res_d.evicted_owner = s_rd[15:0];
            end
          end else if (slot_st == aat_pkg::ST_STALE && s_wa != '0) begin
            s_we = 1'b1; s_wd = {aat_pkg::ST_FREE, s_rd[15:0]};
          end
        end
        cnt_d = (cnt_q == CW'(IdSlots)) ? '0 : cnt_q + CW'(1);
      end
      aat_pkg::S_PTAB: begin
        // fetch tag of entry 0 to start the pipeline
        t_ra = cnt_q[TW-1:0]; tidx_d = cnt_q[TW-1:0];
        cnt_d = cnt_q + CW'(1);
      end
      aat_pkg::S_PTAB_CHK: begin
        // tag of entry cnt_q-1 arrives; look up its slot status next cycle
        t_ra = cnt_q[TW-1:0];
        s_ra = tab_tag[SW+1:2];
        cnt_d = cnt_q + CW'(1);
        tidx_d = cnt_q[TW-1:0];
      end
      aat_pkg::S_ALLOC_WR: begin
        s_we = 1'b1; s_wa = cur_q; s_wd = {aat_pkg::ST_LIVE, req_q.owner_id};
        last_d = cur_q; res_d.given_id = 8'(cur_q);
      end
      aat_pkg::S_RSP: if (!rsp_valid_q || rsp_ready_i) begin
        rsp_d = res_q; rsp_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // purge table stage 2: out-of-range flag and slot status of the entry held in cidx_q
  logic [TW-1:0] cidx_q;
  logic          coor_q, cval_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cval_q <= 1'b0;
    end else begin
      cval_q <= (state_q == aat_pkg::S_PTAB_CHK) && (cnt_q <= CW'(TableEntries));
    end
  end
  always_ff @(posedge clk_i) begin
    cidx_q <= tidx_q;
    coor_q <= tag_id_oor;
  end
  logic clr_hit;
  assign clr_hit = cval_q && (coor_q || slot_st == aat_pkg::ST_FREE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aat_pkg::S_CLR; cnt_q <= '0; last_q <= '0; rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; last_q <= last_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (state_q == aat_pkg::S_IDLE && req_valid_i) req_q <= req_i;
    cur_q <= cur_d; tidx_q <= tidx_d; res_q <= res_d; rsp_q <= rsp_d;
  end

  // clearing writes of the table during purge share the table write port
  always_comb begin
    t_we_f = t_we; t_wa_f = t_wa; t_wd_f = t_wd;
    if (clr_hit) begin
      t_we_f = 1'b1; t_wa_f = cidx_q; t_wd_f = '0;
    end
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb_asid_allocator_with_hashed_tlb.sv
// Testbench for asid_allocator_with_hashed_tlb: directed table then random words,
// scoreboarded against an in-bench predictor. Depends on aat_pkg and the RTL.
`default_nettype none
module tb_asid_allocator_with_hashed_tlb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumEntries = 256;
  localparam int NumSlots   = 256;
  localparam int NumRandom  = 275;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          req_valid_i = 1'b0;
  logic          req_ready_o;
  aat_pkg::req_t req_i = '0;
  logic          rsp_valid_o;
  logic          rsp_ready_i = 1'b0;
  aat_pkg::rsp_t rsp_o;

  asid_allocator_with_hashed_tlb u_top (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Predictor state
  logic [31:0]       tlb_tag [NumEntries];
  logic [31:0]       tlb_mid [NumEntries];
  logic [31:0]       tlb_attr[NumEntries];
  aat_pkg::slot_st_e id_state[NumSlots];
  logic [15:0]       id_owner[NumSlots];
  int unsigned       last_id;

  aat_pkg::rsp_t pending_rsp[$];
  int            err_count = 0;
  int            rsp_count = 0;
  int            evict_count = 0;
  int            hit_count = 0;

  function automatic bit space_free(int unsigned sid);
    if (sid >= NumSlots) return 1'b1;
    return id_state[sid] == aat_pkg::ST_FREE;
  endfunction

  // Compute the response a word causes and update the shadow state
  function automatic aat_pkg::rsp_t predict_rsp(aat_pkg::req_t w);
    aat_pkg::rsp_t r;
    logic [31:0] tag;
    int unsigned idx, i, k;
    r = '0;
    tag = ({12'd0, w.virt_page} << 12) | ({24'd0, w.space_id} << 2);
    idx = (w.virt_page ^ ({12'd0, w.space_id} << 2)) & (NumEntries - 1);
    case (aat_pkg::op_e'(w.op))
      aat_pkg::OP_INSERT: begin
        tlb_tag[idx] = tag;
        tlb_mid[idx] = w.mid_word;
        tlb_attr[idx] = w.attr_word;
        r.entry_index = idx[7:0];
      end
      aat_pkg::OP_LOOKUP: begin
        r.entry_index = idx[7:0];
        if (tlb_tag[idx] == tag) begin
          r.hit = 1'b1;
          r.mid_out = tlb_mid[idx];
          r.attr_out = tlb_attr[idx];
        end
      end
      aat_pkg::OP_ALLOC: begin
        i = last_id;
        for (int s = 0; s < NumSlots; s++) begin
          i++;
          if (i >= NumSlots) i = 1;
          if (id_state[i] == aat_pkg::ST_FREE) break;
        end
        if (i >= NumSlots) i = 1;
        if (id_state[i] != aat_pkg::ST_FREE) begin
          // purge: stale ids go free, victim taken, dead table entries cleared
          for (k = 1; k < NumSlots; k++)
            if (id_state[k] == aat_pkg::ST_STALE) id_state[k] = aat_pkg::ST_FREE;
          if (id_state[i] == aat_pkg::ST_LIVE) begin
            r.evicted_valid = 1'b1;
            r.evicted_owner = id_owner[i];
          end
          id_state[i] = aat_pkg::ST_FREE;
          for (k = 0; k < NumEntries; k++)
            if (space_free((tlb_tag[k] >> 2) & 8'hFF)) begin
              tlb_tag[k] = '0;
              tlb_mid[k] = '0;
              tlb_attr[k] = '0;
            end
        end
        id_state[i] = aat_pkg::ST_LIVE;
        id_owner[i] = w.owner_id;
        last_id = i;
        r.given_id = i[7:0];
      end
      default: begin
        if (w.space_id < NumSlots && id_state[w.space_id] == aat_pkg::ST_LIVE)
          id_state[w.space_id] = aat_pkg::ST_STALE;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Send one word, waiting out random gaps first; valid drops only for a gap
  task automatic send_word(aat_pkg::req_t w, bit fix_known, aat_pkg::rsp_t known);
    aat_pkg::rsp_t p;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= w;
    p = predict_rsp(w);
    if (fix_known && p != known) begin
      $display("%0t: directed row disagrees with predictor", $realtime);
      err_count++;
    end
    pending_rsp.push_back(p);
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  // Response side: random stalls, compare against oldest expectation
  initial begin
    aat_pkg::rsp_t e;
    forever begin
      @(posedge clk_i);
      if (rsp_valid_o && rsp_ready_i) begin
        rsp_count++;
        if (pending_rsp.size() == 0) begin
          $display("%0t: response with nothing expected", $realtime);
          err_count++;
        end else begin
          e = pending_rsp.pop_front();
          if (rsp_o.hit != e.hit) report_mismatch("hit", rsp_o.hit, e.hit);
          if (rsp_o.entry_index != e.entry_index)
            report_mismatch("entry_index", rsp_o.entry_index, e.entry_index);
          if (rsp_o.mid_out != e.mid_out) report_mismatch("mid_out", rsp_o.mid_out, e.mid_out);
          if (rsp_o.attr_out != e.attr_out)
            report_mismatch("attr_out", rsp_o.attr_out, e.attr_out);
          if (rsp_o.given_id != e.given_id)
            report_mismatch("given_id", rsp_o.given_id, e.given_id);
          if (rsp_o.evicted_valid != e.evicted_valid)
            report_mismatch("evicted_valid", rsp_o.evicted_valid, e.evicted_valid);
          if (rsp_o.evicted_owner != e.evicted_owner)
            report_mismatch("evicted_owner", rsp_o.evicted_owner, e.evicted_owner);
          if (e.hit) hit_count++;
          if (e.evicted_valid) evict_count++;
        end
      end
      if ($urandom_range(0, 19) == 0) rsp_ready_i <= 1'b0;
      else if ($urandom_range(0, 2) != 0) rsp_ready_i <= 1'b1;
    end
  end

  function automatic aat_pkg::req_t mk(aat_pkg::op_e op, logic [7:0] sid, logic [19:0] pg,
                                       logic [31:0] m, logic [31:0] a, logic [15:0] own);
    aat_pkg::req_t w;
    w.op = op; w.space_id = sid; w.virt_page = pg;
    w.mid_word = m; w.attr_word = a; w.owner_id = own;
    return w;
  endfunction

  function automatic aat_pkg::rsp_t mk_rsp(logic h, logic [7:0] ix, logic [31:0] m,
                                           logic [31:0] a, logic [7:0] g, logic ev,
                                           logic [15:0] eo);
    aat_pkg::rsp_t r;
    r.hit = h; r.entry_index = ix; r.mid_out = m; r.attr_out = a;
    r.given_id = g; r.evicted_valid = ev; r.evicted_owner = eo;
    return r;
  endfunction

  typedef struct {
    aat_pkg::req_t w;
    bit            known;
    aat_pkg::rsp_t r;
  } row_t;

  // Random word biased toward low space ids and pages so lookups hit
  function automatic aat_pkg::req_t rand_word();
    aat_pkg::req_t w;
    int sel;
    w = '0;
    sel = $urandom_range(0, 99);
    w.op = (sel < 30) ? aat_pkg::OP_INSERT : (sel < 60) ? aat_pkg::OP_LOOKUP :
           (sel < 85) ? aat_pkg::OP_ALLOC : aat_pkg::OP_RELEASE;
    w.space_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    w.virt_page = ($urandom_range(0, 1)) ? 20'($urandom) : 20'($urandom_range(0, 15));
    w.mid_word = $urandom;
    w.attr_word = $urandom;
    w.owner_id = 16'($urandom);
    return w;
  endfunction

  initial begin
    row_t rows[$];
    row_t rw;
    int nrows;
    for (int k = 0; k < NumEntries; k++) begin
      tlb_tag[k] = '0; tlb_mid[k] = '0; tlb_attr[k] = '0;
    end
    for (int k = 0; k < NumSlots; k++) begin
      id_state[k] = aat_pkg::ST_FREE; id_owner[k] = '0;
    end
    last_id = 0;

    // Directed rows: cleared entry hit, extremes, every op, ignored releases
    rows.push_back('{mk(aat_pkg::OP_LOOKUP, 8'd0, 20'd0, '0, '0, '0), 1,
                     mk_rsp(1, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(aat_pkg::OP_LOOKUP, 8'hFF, 20'hFFFFF, '1, '1, '1), 1,
                     mk_rsp(0, 8'h03, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(aat_pkg::OP_INSERT, 8'hFF, 20'hFFFFF, '1, '1, '1), 1,
                     mk_rsp(0, 8'h03, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(aat_pkg::OP_LOOKUP, 8'hFF, 20'hFFFFF, '0, '0, '0), 1,
                     mk_rsp(1, 8'h03, '1, '1, 0, 0, 0)});
    rows.push_back('{mk(aat_pkg::OP_RELEASE, 8'd0, 20'd0, '0, '0, '0), 1,
                     mk_rsp(0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(aat_pkg::OP_RELEASE, 8'd5, 20'd0, '0, '0, '0), 1,
                     mk_rsp(0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(aat_pkg::OP_ALLOC, 8'd0, 20'd0, '0, '0, 16'hFFFF), 1,
                     mk_rsp(0, 0, 0, 0, 8'd1, 0, 0)});
    rows.push_back('{mk(aat_pkg::OP_ALLOC, 8'd0, 20'd0, '0, '0, 16'h0000), 1,
                     mk_rsp(0, 0, 0, 0, 8'd2, 0, 0)});
    rows.push_back('{mk(aat_pkg::OP_INSERT, 8'd1, 20'h12345, 32'hDEADBEEF, 32'h0F0F0F0F, '0),
                     0, '0});
    rows.push_back('{mk(aat_pkg::OP_INSERT, 8'd2, 20'h00010, 32'hA5A5A5A5, 32'h5A5A5A5A, '0),
                     0, '0});
    rows.push_back('{mk(aat_pkg::OP_LOOKUP, 8'd1, 20'h12345, '0, '0, '0), 0, '0});
    rows.push_back('{mk(aat_pkg::OP_LOOKUP, 8'd2, 20'h12345, '0, '0, '0), 0, '0});
    rows.push_back('{mk(aat_pkg::OP_RELEASE, 8'd1, 20'd0, '0, '0, '0), 0, '0});
    rows.push_back('{mk(aat_pkg::OP_RELEASE, 8'd1, 20'd0, '0, '0, '0), 0, '0});
    rows.push_back('{mk(aat_pkg::OP_LOOKUP, 8'd1, 20'h12345, '0, '0, '0), 0, '0});
    rows.push_back('{mk(aat_pkg::OP_INSERT, 8'd200, 20'h00777, 32'h11111111, 32'h22222222,
                        '0), 0, '0});
    // Fill all ids to force purges: stale reclaim, eviction, dead-entry clearing
    for (int k = 0; k < 256; k++)
      rows.push_back('{mk(aat_pkg::OP_ALLOC, 8'd0, 20'd0, '0, '0, 16'(k + 16'h100)), 0, '0});
    rows.push_back('{mk(aat_pkg::OP_LOOKUP, 8'd2, 20'h00010, '0, '0, '0), 0, '0});
    rows.push_back('{mk(aat_pkg::OP_LOOKUP, 8'd200, 20'h00777, '0, '0, '0), 0, '0});
    rows.push_back('{mk(aat_pkg::OP_LOOKUP, 8'hFF, 20'hFFFFF, '0, '0, '0), 0, '0});
    nrows = rows.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < nrows; k++) begin
      rw = rows[k];
      send_word(rw.w, rw.known, rw.r);
    end
    for (int k = 0; k < NumRandom; k++) send_word(rand_word(), 1'b0, '0);
    req_valid_i <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d words: %0d responses, %0d lookup hits, %0d evictions.",
             nrows + NumRandom, rsp_count, hit_count, evict_count);
    if (err_count == 0) begin
      $display("tb_asid_allocator_with_hashed_tlb: PASS");
    end else begin
      $display("tb_asid_allocator_with_hashed_tlb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200ms;
    $display("tb_asid_allocator_with_hashed_tlb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
